// ----- rtl/core/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// ipid_pkg
// shared widths and request types of the integer positional pid controller
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int unsigned DataW   = 16;  // error, gains, divisor, drive
  localparam int unsigned AccumW  = 32;  // integral
  localparam int unsigned SumW    = 48;  // gain sum, quotient
  localparam int unsigned MacBits = 16;  // gain bits per product
  localparam int unsigned DivSteps = SumW;

  typedef struct packed {
    logic              start;
    logic [DataW-1:0]  gain_p;
    logic [DataW-1:0]  gain_i;
    logic [DataW-1:0]  gain_d;
    logic [DataW-1:0]  err;
    logic [AccumW-1:0] accum;
    logic [DataW-1:0]  deriv;
  } mac_req_t;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  num;
    logic [DataW-1:0] den;   // never zero
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/core/ipid_mac.sv -----
// ----------------------------------------------------------------------------
// ipid_mac
// shift-add multiply-accumulate: one gain bit per cycle over the three terms
// ----------------------------------------------------------------------------
module ipid_mac
  import ipid_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_req_t               req_i,
  output unit_sts_t              sts_o,
  output logic signed [SumW-1:0] acc_o
);

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_e;

  term_e                  term_q;
  logic [3:0]             bit_q;
  logic                   busy_q, done_q;
  logic [DataW-1:0]       gain_q;
  logic [SumW-1:0]        opd_q;
  logic signed [SumW-1:0] acc_q;

  logic [DataW-1:0]       nxt_gain;
  logic [SumW-1:0]        nxt_opd;
  term_e                  nxt_term;
  logic [SumW-1:0]        addend;

  // operands of the term after the current one
  always_comb begin
    nxt_term = TERM_D;
    nxt_gain = req_i.gain_d;
    nxt_opd  = {{(SumW-DataW){req_i.deriv[DataW-1]}}, req_i.deriv};
    case (term_q)
      TERM_P: begin
        nxt_term = TERM_I;
        nxt_gain = req_i.gain_i;
        nxt_opd  = {{(SumW-AccumW){req_i.accum[AccumW-1]}}, req_i.accum};
      end
      TERM_I: begin
        nxt_term = TERM_D;
        nxt_gain = req_i.gain_d;
        nxt_opd  = {{(SumW-DataW){req_i.deriv[DataW-1]}}, req_i.deriv};
      end
      default: begin
        nxt_term = TERM_D;
        nxt_gain = req_i.gain_d;
        nxt_opd  = {{(SumW-DataW){req_i.deriv[DataW-1]}}, req_i.deriv};
      end
    endcase
  end

  assign addend = gain_q[0] ? opd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= TERM_P;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        term_q <= TERM_P;
        bit_q  <= '0;
        busy_q <= 1'b1;
        gain_q <= req_i.gain_p;
        opd_q  <= {{(SumW-DataW){req_i.err[DataW-1]}}, req_i.err};
        acc_q  <= '0;
      end else if (busy_q) begin
        // top gain bit carries negative weight
        if (bit_q == 4'(MacBits-1)) begin
          acc_q <= acc_q - $signed(addend);
          bit_q <= '0;
          if (term_q == TERM_D) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            term_q <= nxt_term;
            gain_q <= nxt_gain;
            opd_q  <= nxt_opd;
          end
        end else begin
          acc_q  <= acc_q + $signed(addend);
          bit_q  <= bit_q + 4'd1;
          gain_q <= {1'b0, gain_q[DataW-1:1]};
          opd_q  <= {opd_q[SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

// ----- rtl/core/ipid_div.sv -----
// ----------------------------------------------------------------------------
// ipid_div
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module ipid_div
  import ipid_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  div_req_t               req_i,
  output unit_sts_t              sts_o,
  output logic signed [SumW-1:0] quot_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_e;

  dstate_e          state_q;
  logic [5:0]       cnt_q;
  logic             neg_q, done_q;
  logic [SumW-1:0]  n_q;
  logic [DataW-1:0] d_q;
  logic [DataW-1:0] rem_q;
  logic [SumW-1:0]  quot_q;

  logic [DataW:0]   trial;
  logic [DataW+1:0] diff;
  logic             ge;
  logic [SumW-1:0]  num_abs;
  logic [DataW-1:0] den_abs;

  assign num_abs = req_i.num[SumW-1] ? (~req_i.num + 1'b1) : req_i.num;
  assign den_abs = req_i.den[DataW-1] ? (~req_i.den + 1'b1) : req_i.den;

  assign trial = {rem_q, n_q[SumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_q};
  assign ge    = ~diff[DataW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            n_q     <= num_abs;
            d_q     <= den_abs;
            neg_q   <= req_i.num[SumW-1] ^ req_i.den[DataW-1];
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
          n_q   <= {n_q[SumW-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DivSteps-1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          quot_q  <= neg_q ? (~n_q + 1'b1) : n_q;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign sts_o.busy = (state_q != D_IDLE);
  assign sts_o.done = done_q;
  assign quot_o     = $signed(quot_q);

endmodule

// ----- rtl/core/integer_positional_pid_top.sv -----
// ----------------------------------------------------------------------------
// integer_positional_pid_top
// positional integer pid controller with apb register port
// ----------------------------------------------------------------------------
// a compute transaction reaches drive_o after the update state, 48 shift-add
// steps of the shared multiply-accumulate unit, 48 steps of the restoring
// divider, the clamp and the output state; a clear goes from idle to output.
// one transaction is in the sequencer at a time; a new one is taken only in idle.
// reset clears integral and last error and loads the register reset values.
module integer_positional_pid_top
  import ipid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measured_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] drive_o
);

  localparam logic [2:0] RegGainP      = 3'd0;
  localparam logic [2:0] RegGainI      = 3'd1;
  localparam logic [2:0] RegGainD      = 3'd2;
  localparam logic [2:0] RegDivisor    = 3'd3;
  localparam logic [2:0] RegAccumLimit = 3'd4;
  localparam logic [2:0] RegDriveLow   = 3'd5;
  localparam logic [2:0] RegDriveHigh  = 3'd6;

  localparam logic OpClear = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MAC,
    S_DIV,
    S_CLAMP,
    S_OUT
  } state_e;

  // configuration registers
  logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q, divisor_q;
  logic signed [DataW-1:0] drive_low_q, drive_high_q;
  logic [30:0]             accum_limit_q;
  logic                    cfg_wr;
  logic [2:0]              cfg_idx;

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= '0;
      gain_i_q      <= '0;
      gain_d_q      <= '0;
      divisor_q     <= 16'sd1;
      accum_limit_q <= '0;
      drive_low_q   <= 16'sh8000;
      drive_high_q  <= 16'sh7fff;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegGainP:      gain_p_q      <= pwdata[15:0];
        RegGainI:      gain_i_q      <= pwdata[15:0];
        RegGainD:      gain_d_q      <= pwdata[15:0];
        RegDivisor:    divisor_q     <= pwdata[15:0];
        RegAccumLimit: accum_limit_q <= pwdata[30:0];
        RegDriveLow:   drive_low_q   <= pwdata[15:0];
        RegDriveHigh:  drive_high_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegGainP:      prdata = 32'(gain_p_q);
      RegGainI:      prdata = 32'(gain_i_q);
      RegGainD:      prdata = 32'(gain_d_q);
      RegDivisor:    prdata = 32'(divisor_q);
      RegAccumLimit: prdata = {1'b0, accum_limit_q};
      RegDriveLow:   prdata = 32'(drive_low_q);
      RegDriveHigh:  prdata = 32'(drive_high_q);
      default:       prdata = '0;
    endcase
  end

  // controller state and sequencer
  state_e                   state_q;
  logic signed [AccumW-1:0] accum_q;
  logic signed [DataW-1:0]  prev_q, err_q, deriv_q, res_q, drive_q;
  logic                     out_valid_q, mac_start_q, div_start_q;

  logic signed [AccumW:0]   acc_sum, lim, nlim, acc_clamped;
  logic signed [SumW-1:0]   quot, lo_x, hi_x;
  logic signed [SumW-1:0]   mac_acc;
  logic signed [DataW-1:0]  clamp_res;
  mac_req_t                 mac_req;
  div_req_t                 div_req;
  unit_sts_t                mac_sts, div_sts;

  assign acc_sum = {accum_q[AccumW-1], accum_q} + {{(AccumW-DataW+1){err_q[DataW-1]}}, err_q};
  assign lim     = {2'b00, accum_limit_q};
  assign nlim    = -lim;

  always_comb begin
    if (acc_sum < nlim) begin
      acc_clamped = nlim;
    end else if (acc_sum > lim) begin
      acc_clamped = lim;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  assign lo_x = {{(SumW-DataW){drive_low_q[DataW-1]}}, drive_low_q};
  assign hi_x = {{(SumW-DataW){drive_high_q[DataW-1]}}, drive_high_q};

  always_comb begin
    if (quot < lo_x) begin
      clamp_res = drive_low_q;
    end else if (quot > hi_x) begin
      clamp_res = drive_high_q;
    end else begin
      clamp_res = quot[DataW-1:0];
    end
  end

  assign mac_req.start  = mac_start_q;
  assign mac_req.gain_p = gain_p_q;
  assign mac_req.gain_i = gain_i_q;
  assign mac_req.gain_d = gain_d_q;
  assign mac_req.err    = err_q;
  assign mac_req.accum  = accum_q;
  assign mac_req.deriv  = deriv_q;

  assign div_req.start = div_start_q;
  assign div_req.num   = mac_acc;
  assign div_req.den   = (divisor_q == '0) ? 16'sd1 : divisor_q;

  ipid_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .sts_o  (mac_sts),
    .acc_o  (mac_acc)
  );

  ipid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      accum_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      mac_start_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      mac_start_q <= 1'b0;
      div_start_q <= 1'b0;
      // in S_OUT the result register is handled below
      if (out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (operation_i == OpClear) begin
              accum_q <= '0;
              prev_q  <= '0;
              res_q   <= '0;
              state_q <= S_OUT;
            end else begin
              err_q   <= setpoint_i - measured_i;
              state_q <= S_UPD;
            end
          end
        end
        S_UPD: begin
          accum_q     <= acc_clamped[AccumW-1:0];
          deriv_q     <= err_q - prev_q;
          prev_q      <= err_q;
          mac_start_q <= 1'b1;
          state_q     <= S_MAC;
        end
        S_MAC: begin
          if (mac_sts.done) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          res_q   <= clamp_res;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // result register frees up when its transaction is taken
          if (!out_valid_q || out_ready_i) begin
            drive_q     <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // assertions
  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == OpClear) |=>
      (accum_q == '0 && prev_q == '0))
    else $error("clear transaction left integral or last error non-zero");

  a_accum_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC && mac_start_q) |->
      ($signed({accum_q[AccumW-1], accum_q}) <= lim &&
       $signed({accum_q[AccumW-1], accum_q}) >= nlim))
    else $error("integral outside its limit after update");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_drive_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLAMP && drive_low_q <= drive_high_q) |=>
      (res_q >= drive_low_q && res_q <= drive_high_q))
    else $error("clamped drive outside its bounds");

endmodule

// ----- tb/pid_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_tb_pkg
// register map and operation codes shared by the pid testbench files
// ----------------------------------------------------------------------------
package pid_tb_pkg;

  typedef enum int {
    RegGainP      = 0,
    RegGainI      = 1,
    RegGainD      = 2,
    RegDivisor    = 3,
    RegAccumLimit = 4,
    RegDriveLow   = 5,
    RegDriveHigh  = 6,
    RegUnmapped   = 7
  } pid_reg_e;

  localparam logic OpCompute = 1'b0;
  localparam logic OpClear   = 1'b1;

endpackage

// ----- tb/pid_checker.sv -----
// ----------------------------------------------------------------------------
// pid_checker
// watches the register port and both channels of the integer pid controller,
// keeps its own copy of the registers, integral and last error, predicts the
// drive of every accepted transaction and compares results in order
// ----------------------------------------------------------------------------
module pid_checker
  import pid_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [15:0] setpoint_i,
  input  logic signed [15:0] measured_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [15:0] drive_o,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [15:0] gain_p, gain_i, gain_d, divisor, drive_low, drive_high;
  logic [30:0]        accum_limit;
  logic signed [31:0] integral;
  logic signed [15:0] prev_err;
  logic signed [15:0] drive_expected_q[$];
  int unsigned        fails;

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 200) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // updates integral and last error as the block does and returns the expected drive
  function automatic logic signed [15:0] control_step(input logic op,
                                                      input logic signed [15:0] sp,
                                                      input logic signed [15:0] ms);
    logic signed [15:0] err;
    logic signed [15:0] deriv;
    longint lim, acc, sum, den, quo;
    if (op == OpClear) begin
      integral = '0;
      prev_err = '0;
      return '0;
    end
    err = sp - ms;
    lim = longint'(accum_limit);
    acc = longint'(integral) + longint'(err);
    if (acc < -lim) acc = -lim;
    if (acc > lim) acc = lim;
    integral = acc[31:0];
    deriv    = err - prev_err;
    prev_err = err;
    sum = longint'(gain_p) * longint'(err) + longint'(gain_i) * acc
        + longint'(gain_d) * longint'(deriv);
    den = (divisor == 0) ? 64'sd1 : longint'(divisor);
    quo = sum / den;
    if (quo < longint'(drive_low)) begin
      quo = longint'(drive_low);
    end else if (quo > longint'(drive_high)) begin
      quo = longint'(drive_high);
    end
    return quo[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      gain_p      = '0;
      gain_i      = '0;
      gain_d      = '0;
      divisor     = 16'sd1;
      accum_limit = '0;
      drive_low   = 16'sh8000;
      drive_high  = 16'sd32767;
      integral    = '0;
      prev_err    = '0;
      fails       = 0;
      drive_expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr[4:2]))
          RegGainP:      gain_p      = pwdata[15:0];
          RegGainI:      gain_i      = pwdata[15:0];
          RegGainD:      gain_d      = pwdata[15:0];
          RegDivisor:    divisor     = pwdata[15:0];
          RegAccumLimit: accum_limit = pwdata[30:0];
          RegDriveLow:   drive_low   = pwdata[15:0];
          RegDriveHigh:  drive_high  = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        drive_expected_q.push_back(control_step(operation_i, setpoint_i, measured_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (drive_expected_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d with no transaction outstanding",
                                    drive_o));
        end else begin
          want = drive_expected_q.pop_front();
          if (drive_o !== want) begin
            report_mismatch($sformatf("drive %0d, expected %0d", drive_o, want));
          end
        end
      end
      pending_o    <= drive_expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the integer pid controller: directed register and input
// corners, then phases of random settings and tracking sequences under
// varying sender idling and receiver stalls; verdict from the checker's count
// ----------------------------------------------------------------------------
module tb_top
  import pid_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [4:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               operation_i = OpCompute;
  logic signed [15:0] setpoint_i  = '0;
  logic signed [15:0] measured_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] drive_o;

  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        idle_pct  = 0;
  int unsigned        stall_pct = 0;
  logic signed [15:0] aim, plant;
  logic [15:0]        lo_pick, hi_pick;
  logic [31:0]        limit_pick;

  integer_positional_pid_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  pid_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .setpoint_i   (setpoint_i),
    .measured_i   (measured_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic program_loop(input logic [15:0] gp, input logic [15:0] gi,
                              input logic [15:0] gd, input logic [15:0] dv,
                              input logic [31:0] lim, input logic [15:0] lo,
                              input logic [15:0] hi);
    write_reg(RegGainP, {16'h0, gp});
    write_reg(RegGainI, {16'h0, gi});
    write_reg(RegGainD, {16'h0, gd});
    write_reg(RegDivisor, {16'h0, dv});
    write_reg(RegAccumLimit, lim);
    write_reg(RegDriveLow, {16'h0, lo});
    write_reg(RegDriveHigh, {16'h0, hi});
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic op, input logic [15:0] sp,
                             input logic [15:0] ms);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    setpoint_i  <= sp;
    measured_i  <= ms;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and let every outstanding transaction come back
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_s16();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4, 5:    return 16'(int'($urandom_range(128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unit gains, wide bounds, wrapped errors at the field extremes
    program_loop(16'd1, 16'd1, 16'd1, 16'd1, 32'd100, 16'h8000, 16'h7fff);
    send_sample(OpCompute, 16'h7fff, 16'h8000);
    send_sample(OpCompute, 16'h8000, 16'h7fff);
    send_sample(OpCompute, 16'h0000, 16'h0000);
    send_sample(OpCompute, 16'h7fff, 16'h0000);
    send_sample(OpCompute, 16'h8000, 16'h0000);
    send_sample(OpClear, 16'h7fff, 16'h8000);
    send_sample(OpCompute, 16'hffff, 16'hffff);
    drain();

    // extreme gains, zero divisor, widest integral
    program_loop(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 32'h7fff_ffff,
                 16'h8000, 16'h7fff);
    repeat (4) send_sample(OpCompute, 16'h3fff, 16'hc000);
    send_sample(OpCompute, 16'h8000, 16'h0000);
    send_sample(OpCompute, 16'h0000, 16'h0000);
    drain();

    // limit lowered under a large integral, crossed drive bounds
    program_loop(16'd1, 16'd1, 16'd1, 16'h8000, 32'd5, 16'd100, 16'hff9c);
    send_sample(OpCompute, 16'h0000, 16'h0000);
    send_sample(OpCompute, 16'd1000, 16'h0000);
    send_sample(OpCompute, 16'hfc18, 16'h0000);
    drain();

    // negative unit divisor, zero limit, a write outside the register map
    program_loop(16'h8000, 16'h0000, 16'h7fff, 16'hffff, 32'd0, 16'h8000, 16'h7fff);
    write_reg(RegUnmapped, 32'hffff_ffff);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    send_sample(OpCompute, 16'h8000, 16'h7fff);
    send_sample(OpCompute, 16'h7fff, 16'h8000);
    send_sample(OpClear, 16'h0000, 16'h0000);
    send_sample(OpCompute, 16'h1234, 16'hedcc);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      case ($urandom_range(3))
        0:       limit_pick = 32'd0;
        1:       limit_pick = $urandom_range(1000, 1);
        2:       limit_pick = $urandom;
        default: limit_pick = 32'h7fff_ffff;
      endcase
      lo_pick = pick_s16();
      hi_pick = pick_s16();
      case ($urandom_range(6))
        0: begin lo_pick = 16'h8000; hi_pick = 16'h7fff; end
        1: ;  // leave unordered, bounds may cross
        default: begin
          if ($signed(lo_pick) > $signed(hi_pick)) begin
            {lo_pick, hi_pick} = {hi_pick, lo_pick};
          end
        end
      endcase
      program_loop(pick_s16(), pick_s16(), pick_s16(),
                   ($urandom_range(3) == 0) ? 16'h0000 : pick_s16(),
                   limit_pick, lo_pick, hi_pick);
      aim   = pick_s16();
      plant = 16'($urandom);
      for (int n = 0; n < 125; n++) begin
        if (ph == 4 && n == 60) drain();
        case ($urandom_range(99)) inside
          [0:7]:   send_sample(OpClear, 16'($urandom), 16'($urandom));
          [8:14]:  send_sample(OpCompute, pick_s16(), pick_s16());
          [15:39]: send_sample(OpCompute, 16'($urandom), 16'($urandom));
          default: begin
            // plant follows the set value with a little noise
            if ($urandom_range(9) == 0) aim = pick_s16();
            plant = 16'(int'(plant) + (int'(aim) - int'(plant)) / 4
                        + int'($urandom_range(16)) - 8);
            send_sample(OpCompute, aim, plant);
          end
        endcase
      end
      drain();
    end

    repeat (110) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
